// ----- design/sdre_pkg.sv -----
// Shared types, constants and the control program of the signed radix digit emitter.
package sdre_pkg;

    localparam int VALUE_W         = 32;
    localparam int CHAR_W          = 8;
    localparam int COUNT_W         = 5;
    localparam int WORD_W          = 64;
    localparam int CFG_INDEX_W     = 2;
    localparam int ALPHABET_BYTES  = 16;
    localparam int ALPHA_IDX_W     = 4;
    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int CMP_W           = COUNT_W + 1;
    localparam int DIV_BITS        = 8;
    localparam int STACK_DEPTH     = 32;
    localparam int STK_IDX_W       = 5;
    localparam int ND_W            = 6;

    localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_LOW    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_HIGH   = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_RESET      = 5'd10;
    localparam logic [WORD_W-1:0]  ALPHA_LOW_RESET  = 64'h3736_3534_3332_3130;
    localparam logic [WORD_W-1:0]  ALPHA_HIGH_RESET = 64'h0000_0000_0000_3938;

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
    localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] S_WAIT      = 4'd0;
    localparam logic [STEP_W-1:0] S_CHECK     = 4'd1;
    localparam logic [STEP_W-1:0] S_DIV0      = 4'd2;
    localparam logic [STEP_W-1:0] S_DIV1      = 4'd3;
    localparam logic [STEP_W-1:0] S_DIV2      = 4'd4;
    localparam logic [STEP_W-1:0] S_DIV3      = 4'd5;
    localparam logic [STEP_W-1:0] S_PUSH      = 4'd6;
    localparam logic [STEP_W-1:0] S_SIGN_TEST = 4'd7;
    localparam logic [STEP_W-1:0] S_SIGN      = 4'd8;
    localparam logic [STEP_W-1:0] S_DIGIT     = 4'd9;
    localparam logic [STEP_W-1:0] S_DONE      = 4'd10;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NOP   = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
    localparam logic [OP_W-1:0] OP_DIV   = 3'd2;
    localparam logic [OP_W-1:0] OP_PUSH  = 3'd3;
    localparam logic [OP_W-1:0] OP_SIGN  = 3'd4;
    localparam logic [OP_W-1:0] OP_DIGIT = 3'd5;

    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_NEVER     = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS    = 3'd1;
    localparam logic [COND_W-1:0] C_NO_REQ    = 3'd2;
    localparam logic [COND_W-1:0] C_INVALID   = 3'd3;
    localparam logic [COND_W-1:0] C_LOOP      = 3'd4;
    localparam logic [COND_W-1:0] C_POS       = 3'd5;
    localparam logic [COND_W-1:0] C_STALL     = 3'd6;
    localparam logic [COND_W-1:0] C_EMIT_MORE = 3'd7;

    typedef struct packed {
        logic              in_ready;
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } ctl_t;

    typedef struct packed {
        logic req;
        logic alpha_ok;
        logic div_more;
        logic neg;
        logic out_free;
        logic emit_more;
        logic digits_left;
    } status_t;

    function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
        ctl_t w;
        w = '{in_ready: 1'b0, op: OP_NOP, cond: C_ALWAYS, target: S_WAIT};
        unique case (step)
            S_WAIT:      w = '{in_ready: 1'b1, op: OP_LOAD,  cond: C_NO_REQ,    target: S_WAIT};
            S_CHECK:     w = '{in_ready: 1'b0, op: OP_NOP,   cond: C_INVALID,   target: S_WAIT};
            S_DIV0:      w = '{in_ready: 1'b0, op: OP_DIV,   cond: C_NEVER,     target: S_WAIT};
            S_DIV1:      w = '{in_ready: 1'b0, op: OP_DIV,   cond: C_NEVER,     target: S_WAIT};
            S_DIV2:      w = '{in_ready: 1'b0, op: OP_DIV,   cond: C_NEVER,     target: S_WAIT};
            S_DIV3:      w = '{in_ready: 1'b0, op: OP_DIV,   cond: C_NEVER,     target: S_WAIT};
            S_PUSH:      w = '{in_ready: 1'b0, op: OP_PUSH,  cond: C_LOOP,      target: S_DIV0};
            S_SIGN_TEST: w = '{in_ready: 1'b0, op: OP_NOP,   cond: C_POS,       target: S_DIGIT};
            S_SIGN:      w = '{in_ready: 1'b0, op: OP_SIGN,  cond: C_STALL,     target: S_SIGN};
            S_DIGIT:     w = '{in_ready: 1'b0, op: OP_DIGIT, cond: C_EMIT_MORE, target: S_DIGIT};
            S_DONE:      w = '{in_ready: 1'b0, op: OP_NOP,   cond: C_ALWAYS,    target: S_WAIT};
            default:     w = '{in_ready: 1'b0, op: OP_NOP,   cond: C_ALWAYS,    target: S_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ----- design/signed_radix_digit_emitter_top.sv -----
// Top level of the signed radix digit emitter: configuration registers and unit wiring.
//
//  Channel   Direction  Signals                        Content
//  s_*       in         s_tvalid s_tready s_tdata      one signed 32-bit value per request
//  m_*       out        m_tvalid m_tready m_tdata      one text byte per transfer, m_tlast on final
//  cfg_*     in         cfg_we cfg_index cfg_data      register writes, no read-back
//
// Each digit of a value costs four divider steps of eight quotient bits and one stack push;
// the digits are then emitted from the stack, after a minus sign for a negative value.
// A request with an invalid alphabet is accepted and produces no bytes.
// Reset clears the step counter, the digit count and the output valid flag at once.
// A stalled output holds the sequencer on the emitting step.
module signed_radix_digit_emitter_top
    import sdre_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [VALUE_W-1:0]     s_tdata,   // [31:0] value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [CHAR_W-1:0]      m_tdata,   // [7:0] out_char
    output logic                   m_tlast
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [WORD_W-1:0]  alpha_low_reg, alpha_low_next;
    logic [WORD_W-1:0]  alpha_high_reg, alpha_high_next;
    logic               alpha_ok;
    ctl_t               ctl;
    status_t            stat;

    always_comb
    begin
        count_next      = count_reg;
        alpha_low_next  = alpha_low_reg;
        alpha_high_next = alpha_high_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SYMBOL_COUNT: count_next      = cfg_data[COUNT_W-1:0];
                REG_ALPHA_LOW:    alpha_low_next  = cfg_data;
                REG_ALPHA_HIGH:   alpha_high_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= COUNT_RESET;
            alpha_low_reg  <= ALPHA_LOW_RESET;
            alpha_high_reg <= ALPHA_HIGH_RESET;
        end
        else
        begin
            count_reg      <= count_next;
            alpha_low_reg  <= alpha_low_next;
            alpha_high_reg <= alpha_high_next;
        end
    end

    sdre_alpha #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_alpha (
        .symbol_count       (count_reg),
        .alphabet_low_word  (alpha_low_reg),
        .alphabet_high_word (alpha_high_reg),
        .alpha_ok           (alpha_ok)
    );

    sdre_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    sdre_dp #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctl                (ctl),
        .s_tvalid           (s_tvalid),
        .value              (s_tdata),
        .symbol_count       (count_reg),
        .alphabet_low_word  (alpha_low_reg),
        .alphabet_high_word (alpha_high_reg),
        .alpha_ok           (alpha_ok),
        .m_tready           (m_tready),
        .m_tvalid           (m_tvalid),
        .out_char           (m_tdata),
        .m_tlast            (m_tlast),
        .stat               (stat)
    );

    assign s_tready = ctl.in_ready;

    // No digits may be left over when a new request can be taken.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !stat.digits_left)
        else $error("digits pending while accepting a new value");

    // A digit is only emitted while the stack holds one.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_DIGIT) |-> stat.digits_left)
        else $error("digit emission from an empty stack");

    // The minus sign always precedes at least one digit.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata == MINUS_CHAR) |-> !m_tlast)
        else $error("minus sign marked as final byte");

endmodule

// ----- design/sdre_seq.sv -----
// Microcode sequencer: step counter, program table lookup and conditional jumps.
module sdre_seq
    import sdre_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t stat,
    output ctl_t    ctl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              jump;

    assign ctl = ucode(step_reg);

    always_comb
    begin
        unique case (ctl.cond)
            C_NEVER:     jump = 1'b0;
            C_ALWAYS:    jump = 1'b1;
            C_NO_REQ:    jump = !stat.req;
            C_INVALID:   jump = !stat.alpha_ok;
            C_LOOP:      jump = stat.div_more;
            C_POS:       jump = !stat.neg;
            C_STALL:     jump = !stat.out_free;
            C_EMIT_MORE: jump = !stat.out_free || stat.emit_more;
            default:     jump = 1'b1;
        endcase
        step_next = jump ? ctl.target : step_reg + STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- design/sdre_alpha.sv -----
// Alphabet check: symbol count range, sign characters and duplicate symbols.
module sdre_alpha
    import sdre_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
)
(
    input  logic [COUNT_W-1:0] symbol_count,
    input  logic [WORD_W-1:0]  alphabet_low_word,
    input  logic [WORD_W-1:0]  alphabet_high_word,
    output logic               alpha_ok
);

    logic [2*WORD_W-1:0] alpha_all;
    logic [CHAR_W-1:0]   sym_i;

    assign alpha_all = {alphabet_high_word, alphabet_low_word};

    always_comb
    begin
        alpha_ok = (symbol_count >= COUNT_W'(2)) && (symbol_count <= COUNT_W'(MAX_SYMBOLS));
        sym_i    = '0;
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            sym_i = alpha_all[i*CHAR_W +: CHAR_W];
            if (COUNT_W'(i) < symbol_count)
            begin
                if (sym_i == MINUS_CHAR || sym_i == PLUS_CHAR)
                begin
                    alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++)
                begin
                    if (COUNT_W'(j) < symbol_count && alpha_all[j*CHAR_W +: CHAR_W] == sym_i)
                    begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

endmodule

// ----- design/sdre_dp.sv -----
// Datapath: magnitude and divider registers, digit stack and output register.
module sdre_dp
    import sdre_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_t                ctl,
    input  logic                s_tvalid,
    input  logic [VALUE_W-1:0]  value,
    input  logic [COUNT_W-1:0]  symbol_count,
    input  logic [WORD_W-1:0]   alphabet_low_word,
    input  logic [WORD_W-1:0]   alphabet_high_word,
    input  logic                alpha_ok,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [CHAR_W-1:0]   out_char,
    output logic                m_tlast,
    output status_t             stat
);

    localparam int DIGIT_W = $clog2(MAX_SYMBOLS);
    localparam int REM_W   = DIGIT_W + 1;

    logic [VALUE_W-1:0]   quo_reg, quo_next;
    logic [DIGIT_W-1:0]   rem_reg, rem_next;
    logic [ND_W-1:0]      nd_reg, nd_next;
    logic                 neg_reg, neg_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    out_char_reg, out_char_next;
    logic                 out_last_reg, out_last_next;
    logic [DIGIT_W-1:0]   digit_reg [STACK_DEPTH];
    logic                 push_en;

    logic [VALUE_W-1:0]   mag;
    logic [VALUE_W-1:0]   div_quo;
    logic [DIGIT_W-1:0]   div_rem;
    logic [REM_W-1:0]     div_trial;
    logic [CMP_W-1:0]     div_diff;
    logic                 div_fit;
    logic                 out_free;
    logic [ND_W-1:0]      nd_dec;
    logic [2*WORD_W-1:0]  alpha_all;
    logic [ALPHA_IDX_W-1:0] sym_idx;
    logic [CHAR_W-1:0]    sym_char;

    assign mag       = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
    assign out_free  = !out_valid_reg || m_tready;
    assign nd_dec    = nd_reg - ND_W'(1);
    assign alpha_all = {alphabet_high_word, alphabet_low_word};
    assign sym_idx   = ALPHA_IDX_W'(digit_reg[nd_dec[STK_IDX_W-1:0]]);
    assign sym_char  = alpha_all[{sym_idx, 3'b000} +: CHAR_W];

    always_comb
    begin
        div_rem   = rem_reg;
        div_quo   = quo_reg;
        div_trial = '0;
        div_diff  = '0;
        div_fit   = 1'b0;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            div_trial = {div_rem, div_quo[VALUE_W-1]};
            div_fit   = CMP_W'(div_trial) >= CMP_W'(symbol_count);
            div_diff  = CMP_W'(div_trial) - CMP_W'(symbol_count);
            div_rem   = div_fit ? div_diff[DIGIT_W-1:0] : div_trial[DIGIT_W-1:0];
            div_quo   = {div_quo[VALUE_W-2:0], div_fit};
        end
    end

    always_comb
    begin
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        nd_next        = nd_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        push_en        = 1'b0;
        unique case (ctl.op)
            OP_LOAD:
            begin
                if (s_tvalid && ctl.in_ready)
                begin
                    quo_next = mag;
                    rem_next = '0;
                    nd_next  = '0;
                    neg_next = value[VALUE_W-1];
                end
            end
            OP_DIV:
            begin
                quo_next = div_quo;
                rem_next = div_rem;
            end
            OP_PUSH:
            begin
                push_en  = 1'b1;
                nd_next  = nd_reg + ND_W'(1);
                rem_next = '0;
            end
            OP_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = MINUS_CHAR;
                    out_last_next  = 1'b0;
                end
            end
            OP_DIGIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = sym_char;
                    out_last_next  = nd_reg == ND_W'(1);
                    nd_next        = nd_dec;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nd_reg        <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            nd_reg        <= nd_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        if (push_en)
        begin
            digit_reg[nd_reg[STK_IDX_W-1:0]] <= rem_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign out_char = out_char_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        stat.req         = s_tvalid;
        stat.alpha_ok    = alpha_ok;
        stat.div_more    = (quo_reg != '0) && (nd_reg != ND_W'(STACK_DEPTH - 1));
        stat.neg         = neg_reg;
        stat.out_free    = out_free;
        stat.emit_more   = nd_reg != ND_W'(1);
        stat.digits_left = nd_reg != '0;
    end

endmodule

// ----- test/sdre_text_check.sv -----
// Checker for the signed radix digit emitter: predicts each text run and compares output bytes.
module sdre_text_check
    import sdre_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [VALUE_W-1:0]     s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [CHAR_W-1:0]      m_tdata,
    input  logic                   m_tlast,
    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              tail;
    } text_byte_t;

    text_byte_t             expected_text[$];
    text_byte_t             want;
    logic [COUNT_W-1:0]     radix_reg;
    logic [WORD_W-1:0]      alpha_word_lo;
    logic [WORD_W-1:0]      alpha_word_hi;
    int                     mismatches;

    function automatic logic [CHAR_W-1:0] symbol_byte(input int idx);
        logic [2*WORD_W-1:0] both;
        both = {alpha_word_hi, alpha_word_lo};
        return both[idx*CHAR_W +: CHAR_W];
    endfunction

    // Works out the bytes of one value: a minus sign if negative, then the digits,
    // most significant first. An unusable alphabet gives no bytes at all.
    task automatic predict_text(input logic [VALUE_W-1:0] raw);
        logic                   ok;
        logic                   neg;
        logic [VALUE_W-1:0]     mag;
        logic [VALUE_W-1:0]     radix;
        logic [ALPHA_IDX_W-1:0] digit_stack[STACK_DEPTH];
        int                     nd;
        ok = (radix_reg >= 2) && (radix_reg <= MAX_SYMBOLS_DEF);
        for (int i = 0; ok && i < radix_reg; i++)
        begin
            if (symbol_byte(i) == MINUS_CHAR || symbol_byte(i) == PLUS_CHAR)
                ok = 1'b0;
            for (int j = i + 1; j < radix_reg; j++)
                if (symbol_byte(j) == symbol_byte(i))
                    ok = 1'b0;
        end
        if (!ok)
            return;
        neg   = raw[VALUE_W-1];
        mag   = neg ? (32'd0 - raw) : raw;
        radix = {{(VALUE_W-COUNT_W){1'b0}}, radix_reg};
        nd    = 0;
        do
        begin
            digit_stack[nd] = ALPHA_IDX_W'(mag % radix);
            mag = mag / radix;
            nd++;
        end
        while (mag != 0 && nd < STACK_DEPTH);
        if (neg)
            expected_text.push_back('{ch: MINUS_CHAR, tail: 1'b0});
        for (int k = nd - 1; k >= 0; k--)
            expected_text.push_back('{ch: symbol_byte(digit_stack[k]), tail: (k == 0)});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     = COUNT_RESET;
            alpha_word_lo = ALPHA_LOW_RESET;
            alpha_word_hi = ALPHA_HIGH_RESET;
            mismatches    = 0;
            expected_text.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SYMBOL_COUNT: radix_reg     = cfg_data[COUNT_W-1:0];
                    REG_ALPHA_LOW:    alpha_word_lo = cfg_data;
                    REG_ALPHA_HIGH:   alpha_word_hi = cfg_data;
                    default:          ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_text.size() == 0)
                begin
                    $display("%0t: unexpected byte, expected none, actual char %h last %b",
                             $time, m_tdata, m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (m_tdata !== want.ch || m_tlast !== want.tail)
                    begin
                        $display("%0t: byte mismatch, expected char %h last %b, actual char %h last %b",
                                 $time, want.ch, want.tail, m_tdata, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_text(s_tdata);
            fail_count <= mismatches;
            pending    <= expected_text.size();
        end
    end

endmodule

// ----- test/tb_signed_radix_digit_emitter_top.sv -----
// Testbench top for the signed radix digit emitter: stimulus, stalls, watchdog and verdict.
module tb_signed_radix_digit_emitter_top;
    import sdre_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 4000;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]      cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [VALUE_W-1:0]     s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [CHAR_W-1:0]      m_tdata;
    logic                   m_tlast;

    int                     text_pending;
    int                     text_failures;
    int                     idle_cycles = 0;
    int                     ready_hold  = 0;
    int                     ready_gap;
    logic                   calm        = 1'b0;
    int                     cur_radix;
    int                     phase;
    int                     n;
    logic [2*WORD_W-1:0]    alphabet;
    logic [WORD_W-1:0]      count_word;

    signed_radix_digit_emitter_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    sdre_text_check text_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (text_failures),
        .pending    (text_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one; none at all in calm stretches.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(input int radix);
        longint           power;
        logic [VALUE_W-1:0] v;
        int               k;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 3 * radix);
            2: v = 32'd0 - $urandom_range(1, 3 * radix);
            3:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            4:
            begin
                power = 1;
                k = $urandom_range(1, 31);
                while (k > 0 && power * radix <= 64'h8000_0000)
                begin
                    power = power * radix;
                    k--;
                end
                v = power[31:0] + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1))
                    v = 32'd0 - v;
            end
            default:
            begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                    v = 32'd0 - v;
            end
        endcase
        return v;
    endfunction

    // Sixteen distinct bytes, none of them a sign character.
    function automatic logic [2*WORD_W-1:0] pick_alphabet();
        logic [2*WORD_W-1:0] a;
        logic [255:0]        used;
        logic [CHAR_W-1:0]   b;
        used = '0;
        used[MINUS_CHAR] = 1'b1;
        used[PLUS_CHAR]  = 1'b1;
        for (int i = 0; i < ALPHABET_BYTES; i++)
        begin
            b = CHAR_W'($urandom_range(0, 255));
            while (used[b])
                b = CHAR_W'($urandom_range(0, 255));
            used[b] = 1'b1;
            a[i*CHAR_W +: CHAR_W] = b;
        end
        return a;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Hold off new requests until every predicted byte has come out and the block is idle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (text_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            ready_hold <= 0;
        end
        else if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else if (!m_tready || calm)
        begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 6);
        end
        else
        begin
            ready_gap = gap_len();
            if (ready_gap > 0)
            begin
                m_tready   <= 1'b0;
                ready_hold <= ready_gap - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset alphabet, decimal.
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd10);
        send_value(32'hFFFF_FFF7);
        send_value(32'd123456789);

        // Binary with a zero byte as a symbol; bytes beyond the radix are ignored.
        wait_idle();
        write_reg(REG_SYMBOL_COUNT, 64'd2);
        write_reg(REG_ALPHA_LOW, 64'h2D2B_FFFF_FFFF_FF00);
        write_reg(REG_ALPHA_HIGH, '1);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'd0);
        send_value(32'hFFFF_FFFF);

        // Full sixteen-symbol alphabet.
        wait_idle();
        write_reg(REG_SYMBOL_COUNT, 64'd16);
        write_reg(REG_ALPHA_LOW, 64'h8040_2010_0804_0201);
        write_reg(REG_ALPHA_HIGH, 64'h7FBF_DFEF_F7FB_FDFE);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'hFEDC_BA98);
        send_value(32'h0123_4567);

        // Unusable alphabets: too few symbols, too many, a sign in use, a duplicate.
        wait_idle();
        write_reg(REG_SYMBOL_COUNT, 64'd1);
        send_value(32'd5);
        wait_idle();
        write_reg(REG_SYMBOL_COUNT, 64'd0);
        send_value(32'hFFFF_FFFB);
        wait_idle();
        write_reg(REG_SYMBOL_COUNT, 64'd17);
        send_value(32'd77);
        wait_idle();
        write_reg(REG_SYMBOL_COUNT, 64'd31);
        send_value(32'd77);
        wait_idle();
        write_reg(REG_SYMBOL_COUNT, 64'd3);
        write_reg(REG_ALPHA_LOW, 64'h0000_0000_0032_2B31);
        send_value(32'd9);
        wait_idle();
        write_reg(REG_ALPHA_LOW, 64'h0000_0000_002D_3130);
        send_value(32'd9);
        wait_idle();
        write_reg(REG_SYMBOL_COUNT, 64'd2);
        write_reg(REG_ALPHA_LOW, '0);
        write_reg(REG_ALPHA_HIGH, '0);
        send_value(32'd9);

        // A write to the unused index must leave the decimal setup untouched.
        wait_idle();
        write_reg(REG_SYMBOL_COUNT, 64'd10);
        write_reg(REG_ALPHA_LOW, ALPHA_LOW_RESET);
        write_reg(REG_ALPHA_HIGH, ALPHA_HIGH_RESET);
        write_reg(REG_UNUSED, '1);
        send_value(32'h8000_0000);

        for (phase = 0; phase < 9; phase++)
        begin
            wait_idle();
            calm = (phase % 4 == 1);
            count_word = {$urandom, $urandom};
            if ($urandom_range(0, 4) == 0)
            begin
                count_word[COUNT_W-1:0] = COUNT_W'($urandom_range(0, 31));
                alphabet = {$urandom, $urandom, $urandom, $urandom};
                cur_radix = 10;
            end
            else
            begin
                cur_radix = $urandom_range(2, 16);
                count_word[COUNT_W-1:0] = COUNT_W'(cur_radix);
                alphabet = pick_alphabet();
            end
            write_reg(REG_SYMBOL_COUNT, count_word);
            write_reg(REG_ALPHA_LOW, alphabet[WORD_W-1:0]);
            write_reg(REG_ALPHA_HIGH, alphabet[2*WORD_W-1:WORD_W]);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, {$urandom, $urandom});
            for (n = 0; n < 10; n++)
                send_value(pick_value(cur_radix));
        end

        wait_idle();
        if (text_failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
